FILE: sv/fscd_pkg.sv
// ----------------------------------------------------------------------------
// fscd_pkg
// shared types and constants of the sensor change detector
// ----------------------------------------------------------------------------
package fscd_pkg;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int AGE_W    = 4;
    localparam int MOD_W    = 3;
    localparam int PIN_W    = 5;
    localparam int PCODE_W  = 4;
    localparam int ENTRY_W  = MOD_W + PCODE_W;
    localparam int COUNT_W  = 5;

    localparam logic [PIN_W-1:0] PIN_BASE_LO = 5'd8;
    localparam logic [PIN_W-1:0] PIN_BASE_HI = 5'd16;

    typedef enum logic [1:0] {
        KIND_EVENT   = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_READ    = 2'd2
    } t_kind;

    typedef struct packed {
        logic             bit_diff;
        logic             level;
        logic             more;
        logic [PIN_W-1:0] pin;
    } t_scan_view;

endpackage

FILE: sv/fscd_bitscan.sv
// ----------------------------------------------------------------------------
// fscd_bitscan
// shift unit that walks the changed bits of one byte, lsb first
// ----------------------------------------------------------------------------
module fscd_bitscan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic [fscd_pkg::BYTE_W-1:0] i_diff,
    input  logic [fscd_pkg::BYTE_W-1:0] i_data,
    input  logic                       i_odd,
    output fscd_pkg::t_scan_view       o_view
);
    import fscd_pkg::*;

    logic [BYTE_W-1:0] r_diff;
    logic [BYTE_W-1:0] r_data;
    logic [PIN_W-1:0]  r_pin;
    logic [BYTE_W-1:0] n_diff;
    logic [BYTE_W-1:0] n_data;
    logic [PIN_W-1:0]  n_pin;

    always_comb begin
        n_diff = r_diff;
        n_data = r_data;
        n_pin  = r_pin;
        if (i_load) begin
            n_diff = i_diff;
            n_data = i_data;
            n_pin  = i_odd ? PIN_BASE_HI : PIN_BASE_LO;
        end else if (i_step) begin
            n_diff = r_diff >> 1;
            n_data = r_data >> 1;
            n_pin  = r_pin - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= '0;
        end else begin
            r_diff <= n_diff;
        end
        r_data <= n_data;
        r_pin  <= n_pin;
    end

    assign o_view.bit_diff = r_diff[0];
    assign o_view.level    = r_data[0];
    assign o_view.more     = |r_diff[BYTE_W-1:1];
    assign o_view.pin      = r_pin;

`ifndef SYNTH
    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && i_step))
        else $error("load and step in the same cycle");
    a_step_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_load) |=> (r_diff == ($past(r_diff) >> 1)))
        else $error("step did not shift the diff bits");
    a_pin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_diff != '0) |-> (r_pin != '0))
        else $error("pending bit with pin zero");
`endif

endmodule

FILE: sv/fscd_history.sv
// ----------------------------------------------------------------------------
// fscd_history
// wrapping ring of rising-edge entries with fill count and read by age
// ----------------------------------------------------------------------------
module fscd_history #(
    parameter int HISTORY_DEPTH = 16,
    localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
    localparam int FW = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [fscd_pkg::ENTRY_W-1:0]  i_entry,
    input  logic                          i_rd_en,
    input  logic [fscd_pkg::AGE_W-1:0]    i_age,
    output logic                          o_age_ok,
    output logic [fscd_pkg::ENTRY_W-1:0]  o_rd_data,
    output logic [FW-1:0]                 o_fill,
    output logic [FW-1:0]                 o_fill_after_push
);
    import fscd_pkg::*;

    localparam int CW = (FW > AGE_W) ? FW : AGE_W;
    localparam int AW = ((SW > AGE_W) ? SW : AGE_W) + 2;

    logic [ENTRY_W-1:0] r_ring [HISTORY_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [SW-1:0]      r_newest;
    logic [FW-1:0]      r_fill;
    logic [SW-1:0]      n_newest;
    logic [FW-1:0]      n_fill;
    logic [SW-1:0]      wr_slot;
    logic [SW-1:0]      rd_slot;
    logic [AW-1:0]      back_sum;
    logic               fill_full;

    assign fill_full = (r_fill == FW'(HISTORY_DEPTH));

    always_comb begin
        if (r_newest == SW'(HISTORY_DEPTH - 1)) begin
            wr_slot = '0;
        end else begin
            wr_slot = r_newest + SW'(1);
        end
        if (r_fill == '0) begin
            wr_slot = r_newest;
        end
    end

    always_comb begin
        back_sum = AW'(r_newest) + AW'(HISTORY_DEPTH) - AW'(i_age);
        if (back_sum >= AW'(HISTORY_DEPTH)) begin
            back_sum = back_sum - AW'(HISTORY_DEPTH);
        end
        rd_slot = back_sum[SW-1:0];
    end

    assign o_age_ok          = (CW'(i_age) < CW'(r_fill));
    assign o_fill_after_push = fill_full ? r_fill : r_fill + FW'(1);

    always_comb begin
        n_newest = r_newest;
        n_fill   = r_fill;
        if (i_push) begin
            n_newest = wr_slot;
            n_fill   = o_fill_after_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_fill   <= '0;
        end else begin
            r_newest <= n_newest;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ring[wr_slot] <= i_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_ring[rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("history fill above depth");
    a_newest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_newest) < CW'(HISTORY_DEPTH))
        else $error("newest slot out of range");
    a_push_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && i_rd_en))
        else $error("push and read in the same cycle");
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !fill_full) |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("fill did not grow on push");
`endif

endmodule

FILE: sv/feedback_sensor_change_detector_core.sv
// ----------------------------------------------------------------------------
// feedback_sensor_change_detector_core
// per-bit change events, rising-edge history ring and history reads
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall, a transfer when i_valid and !o_stall.
//   command 0 carries one byte of the sensor dump at i_byte_index; command 1
//   reads the history entry i_age entries back (0 = newest).
// output channel: o_valid / i_stall, zero or more results per transfer, o_last marks
//   the final result of an input item. a result register sits on the output.
// a scan byte walks its bits through a shift unit, one bit a cycle unless an
//   event waits on a full output register, up to its highest changed bit, and
//   gives one change event per changed bit; the last dump byte adds a
//   summary. a history read goes through the registered ring read. an index
//   beyond the dump is dropped.
// o_stall is high while an item is worked on; an event, summary or read result
//   waits in place while i_stall holds the output register full.
// reset (synchronous, active low) clears stored bytes, history count and
//   the rise flag; ring contents stay undefined until written.
// ----------------------------------------------------------------------------
module feedback_sensor_change_detector_core #(
    parameter int HISTORY_DEPTH = 16,
    parameter int MODULE_COUNT  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [fscd_pkg::INDEX_W-1:0]  i_byte_index,
    input  logic [fscd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [fscd_pkg::AGE_W-1:0]    i_age,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_kind,
    output logic [fscd_pkg::MOD_W-1:0]    o_module_res,
    output logic [fscd_pkg::PIN_W-1:0]    o_pin,
    output logic                          o_level,
    output logic                          o_any_rising,
    output logic [fscd_pkg::COUNT_W-1:0]  o_history_count,
    output logic                          o_entry_valid,
    output logic                          o_last
);
    import fscd_pkg::*;

    localparam int DUMP_BYTES = 2 * MODULE_COUNT;
    localparam int IW = $clog2(DUMP_BYTES);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SUM,
        S_READ
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [BYTE_W-1:0]  r_prev [DUMP_BYTES];
    logic [BYTE_W-1:0]  n_prev [DUMP_BYTES];
    logic               r_rise;
    logic               n_rise;
    logic               r_last_byte;
    logic               n_last_byte;
    logic [MOD_W-1:0]   r_mod;
    logic [MOD_W-1:0]   n_mod;
    logic               r_rd_ok;
    logic               n_rd_ok;

    logic               r_o_valid;
    t_kind              r_o_kind;
    logic [MOD_W-1:0]   r_o_mod;
    logic [PIN_W-1:0]   r_o_pin;
    logic               r_o_level;
    logic               r_o_rising;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_entry;
    logic               r_o_last;
    logic               n_o_valid;
    t_kind              n_o_kind;
    logic [MOD_W-1:0]   n_o_mod;
    logic [PIN_W-1:0]   n_o_pin;
    logic               n_o_level;
    logic               n_o_rising;
    logic [COUNT_W-1:0] n_o_count;
    logic               n_o_entry;
    logic               n_o_last;

    logic               in_xfer;
    logic               out_free;
    logic               in_range;
    logic [BYTE_W-1:0]  diff;
    logic               scan_load;
    logic               scan_step;
    t_scan_view         view;
    logic               push;
    logic               rd_en;
    logic               age_ok;
    logic [ENTRY_W-1:0] rd_data;
    logic [FW-1:0]      fill;
    logic [FW-1:0]      fill_after_push;
    logic [ENTRY_W-1:0] push_entry;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign in_range = ({1'b0, i_byte_index} < (INDEX_W + 1)'(DUMP_BYTES));
    assign diff     = i_data_byte ^ r_prev[i_byte_index[IW-1:0]];

    assign push_entry = {r_mod, view.pin[PCODE_W-1:0] - PCODE_W'(1)};

    fscd_bitscan u_bitscan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (scan_load),
        .i_step  (scan_step),
        .i_diff  (diff),
        .i_data  (i_data_byte),
        .i_odd   (i_byte_index[0]),
        .o_view  (view)
    );

    fscd_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_entry           (push_entry),
        .i_rd_en           (rd_en),
        .i_age             (i_age),
        .o_age_ok          (age_ok),
        .o_rd_data         (rd_data),
        .o_fill            (fill),
        .o_fill_after_push (fill_after_push)
    );

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_rise      = r_rise;
        n_last_byte = r_last_byte;
        n_mod       = r_mod;
        n_rd_ok     = r_rd_ok;
        n_o_valid   = r_o_valid && i_stall;
        n_o_kind    = r_o_kind;
        n_o_mod     = r_o_mod;
        n_o_pin     = r_o_pin;
        n_o_level   = r_o_level;
        n_o_rising  = r_o_rising;
        n_o_count   = r_o_count;
        n_o_entry   = r_o_entry;
        n_o_last    = r_o_last;
        scan_load   = 1'b0;
        scan_step   = 1'b0;
        push        = 1'b0;
        rd_en       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_command) begin
                        rd_en   = 1'b1;
                        n_rd_ok = age_ok;
                        n_state = S_READ;
                    end else if (in_range) begin
                        n_prev[i_byte_index[IW-1:0]] = i_data_byte;
                        n_last_byte = (i_byte_index == INDEX_W'(DUMP_BYTES - 1));
                        n_mod       = i_byte_index[INDEX_W-1:1];
                        scan_load   = 1'b1;
                        if (diff != '0) begin
                            n_state = S_SCAN;
                        end else if (n_last_byte) begin
                            n_state = S_SUM;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!view.bit_diff || out_free) begin
                    scan_step = 1'b1;
                    if (view.bit_diff) begin
                        n_o_valid  = 1'b1;
                        n_o_kind   = KIND_EVENT;
                        n_o_mod    = r_mod;
                        n_o_pin    = view.pin;
                        n_o_level  = view.level;
                        n_o_rising = 1'b0;
                        n_o_entry  = 1'b0;
                        n_o_last   = !view.more && !r_last_byte;
                        n_o_count  = COUNT_W'(fill);
                        if (view.level) begin
                            push      = 1'b1;
                            n_rise    = 1'b1;
                            n_o_count = COUNT_W'(fill_after_push);
                        end
                    end
                    if (!view.more) begin
                        n_state = r_last_byte ? S_SUM : S_IDLE;
                    end
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_SUMMARY;
                    n_o_mod    = '0;
                    n_o_pin    = '0;
                    n_o_level  = 1'b0;
                    n_o_rising = r_rise;
                    n_o_count  = COUNT_W'(fill);
                    n_o_entry  = 1'b0;
                    n_o_last   = 1'b1;
                    n_rise     = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = KIND_READ;
                    n_o_mod    = r_rd_ok ? rd_data[ENTRY_W-1:PCODE_W] : '0;
                    n_o_pin    = r_rd_ok ? PIN_W'(rd_data[PCODE_W-1:0]) + PIN_W'(1) : '0;
                    n_o_level  = r_rd_ok;
                    n_o_rising = 1'b0;
                    n_o_count  = COUNT_W'(fill);
                    n_o_entry  = r_rd_ok;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '{default: '0};
            r_rise    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_rise    <= n_rise;
            r_o_valid <= n_o_valid;
        end
        r_last_byte <= n_last_byte;
        r_mod       <= n_mod;
        r_rd_ok     <= n_rd_ok;
        r_o_kind    <= n_o_kind;
        r_o_mod     <= n_o_mod;
        r_o_pin     <= n_o_pin;
        r_o_level   <= n_o_level;
        r_o_rising  <= n_o_rising;
        r_o_count   <= n_o_count;
        r_o_entry   <= n_o_entry;
        r_o_last    <= n_o_last;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_module_res    = r_o_mod;
    assign o_pin           = r_o_pin;
    assign o_level         = r_o_level;
    assign o_any_rising    = r_o_rising;
    assign o_history_count = r_o_count;
    assign o_entry_valid   = r_o_entry;
    assign o_last          = r_o_last;

`ifndef SYNTH
    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command) |=> (r_state == S_READ))
        else $error("read transfer did not start a ring read");
    a_summary_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == KIND_SUMMARY) |->
        (r_o_last && r_o_pin == '0 && r_o_mod == '0))
        else $error("malformed summary result");
    a_entry_is_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_entry) |-> (r_o_kind == KIND_READ && r_o_level))
        else $error("entry_valid outside a valid history read");
    a_rise_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_rise)
        else $error("rising edge pushed without rise flag");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> (r_o_valid && $stable(r_o_pin) && $stable(r_o_kind)))
        else $error("held result overwritten");
`endif

endmodule

FILE: dv/feedback_sensor_change_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_sensor_change_detector_core_tb
// self-checking bench: a directed table of scan bytes and history reads, then
// random dump sequences, reads and stray bytes under several idle and stall
// mixes and one long output hold-off, each result checked against a
// bit-level predictor of change events, summaries and the rising-edge history
// ----------------------------------------------------------------------------
module feedback_sensor_change_detector_core_tb;

    import fscd_pkg::*;

    localparam int HISTORY_DEPTH = 16;
    localparam int MODULE_COUNT  = 5;
    localparam int DUMP_BYTES    = 2 * MODULE_COUNT;
    localparam int RANDOM_ITEMS  = 280;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DUMP_BYTES - 1);

    typedef struct packed {
        t_kind              kind;
        logic [MOD_W-1:0]   module_res;
        logic [PIN_W-1:0]   pin;
        logic               level;
        logic               any_rising;
        logic [COUNT_W-1:0] history_count;
        logic               entry_valid;
        logic               last;
    } t_sensor_result;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  data_byte;
        logic [AGE_W-1:0]   age;
        logic               typed;
        t_sensor_result     want;
    } t_stim_row;

    localparam t_sensor_result NO_RESULT  = '0;
    localparam t_sensor_result READ_EMPTY =
        '{KIND_READ, 3'd0, 5'd0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1};
    localparam t_sensor_result QUIET_SUMMARY =
        '{KIND_SUMMARY, 3'd0, 5'd0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1};

    localparam t_stim_row DIRECTED [24] = '{
        '{CMD_READ, 4'd0,       8'h00, 4'd0,  1'b1, READ_EMPTY},
        '{CMD_READ, 4'd15,      8'hff, 4'd15, 1'b1, READ_EMPTY},
        '{CMD_SCAN, LAST_INDEX, 8'h00, 4'd0,  1'b1, QUIET_SUMMARY},
        '{CMD_SCAN, 4'd10,      8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd15,      8'hff, 4'd15, 1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd0,       8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd0,       8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd1,       8'h01, 4'd0,  1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd0,  1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd8,  1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd9,  1'b0, NO_RESULT},
        '{CMD_SCAN, LAST_INDEX, 8'h80, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, LAST_INDEX, 8'h00, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd0,       8'h00, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd2,       8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd3,       8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd4,       8'hff, 4'd0,  1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd15, 1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd8,       8'haa, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, LAST_INDEX, 8'h55, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd7,       8'h0f, 4'd0,  1'b0, NO_RESULT},
        '{CMD_SCAN, 4'd6,       8'hf0, 4'd0,  1'b0, NO_RESULT},
        '{CMD_READ, 4'd0,       8'h00, 4'd7,  1'b0, NO_RESULT}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_command;
    logic [INDEX_W-1:0]  i_byte_index;
    logic [BYTE_W-1:0]   i_data_byte;
    logic [AGE_W-1:0]    i_age;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_kind;
    logic [MOD_W-1:0]    o_module_res;
    logic [PIN_W-1:0]    o_pin;
    logic                o_level;
    logic                o_any_rising;
    logic [COUNT_W-1:0]  o_history_count;
    logic                o_entry_valid;
    logic                o_last;

    // predictor state
    logic [BYTE_W-1:0]   last_scan [DUMP_BYTES];
    logic [ENTRY_W-1:0]  rise_log [HISTORY_DEPTH];
    int unsigned         log_head;
    int unsigned         log_fill;
    logic                scan_rose;

    t_sensor_result      item_results [$];
    t_sensor_result      pending_results [$];

    int                  mismatch_count = 0;
    int                  counted_items = 0;
    int                  cycle_count = 0;
    int                  sender_idle_pct = 0;
    int                  stall_pct = 0;
    bit                  hold_req = 1'b0;

    feedback_sensor_change_detector_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MODULE_COUNT  (MODULE_COUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_byte_index    (i_byte_index),
        .i_data_byte     (i_data_byte),
        .i_age           (i_age),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_module_res    (o_module_res),
        .o_pin           (o_pin),
        .o_level         (o_level),
        .o_any_rising    (o_any_rising),
        .o_history_count (o_history_count),
        .o_entry_valid   (o_entry_valid),
        .o_last          (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic string fmt_result(input t_sensor_result r);
        return $sformatf("kind=%0d mod=%0d pin=%0d level=%0b rise=%0b count=%0d valid=%0b last=%0b",
                         r.kind, r.module_res, r.pin, r.level, r.any_rising,
                         r.history_count, r.entry_valid, r.last);
    endfunction

    // results caused by one accepted item, left in item_results
    task automatic detect_changes(input logic cmd, input logic [INDEX_W-1:0] idx,
                                  input logic [BYTE_W-1:0] data, input logic [AGE_W-1:0] age);
        t_sensor_result   r;
        int unsigned      slot;
        logic [MOD_W-1:0] mod;
        logic [PIN_W-1:0] base;
        logic [PIN_W-1:0] pin_no;
        item_results.delete();
        if (cmd == CMD_READ) begin
            r = '0;
            r.kind = KIND_READ;
            if (age < log_fill) begin
                slot = (log_head + HISTORY_DEPTH - age) % HISTORY_DEPTH;
                r.module_res  = rise_log[slot][ENTRY_W-1:PCODE_W];
                r.pin         = {1'b0, rise_log[slot][PCODE_W-1:0]} + 5'd1;
                r.level       = 1'b1;
                r.entry_valid = 1'b1;
            end
            r.history_count = COUNT_W'(log_fill);
            r.last = 1'b1;
            item_results.push_back(r);
        end else if (idx < DUMP_BYTES) begin
            mod  = idx[INDEX_W-1:1];
            base = idx[0] ? PIN_BASE_HI : PIN_BASE_LO;
            for (int b = 0; b < BYTE_W; b++) begin
                if (data[b] != last_scan[idx][b]) begin
                    pin_no = base - PIN_W'(b);
                    if (data[b]) begin
                        if (log_fill != 0)
                            log_head = (log_head + 1) % HISTORY_DEPTH;
                        rise_log[log_head] = {mod, PCODE_W'(pin_no - 5'd1)};
                        if (log_fill < HISTORY_DEPTH)
                            log_fill++;
                        scan_rose = 1'b1;
                    end
                    r = '0;
                    r.kind          = KIND_EVENT;
                    r.module_res    = mod;
                    r.pin           = pin_no;
                    r.level         = data[b];
                    r.history_count = COUNT_W'(log_fill);
                    item_results.push_back(r);
                end
            end
            last_scan[idx] = data;
            if (idx == LAST_INDEX) begin
                r = '0;
                r.kind          = KIND_SUMMARY;
                r.any_rising    = scan_rose;
                r.history_count = COUNT_W'(log_fill);
                item_results.push_back(r);
                scan_rose = 1'b0;
            end
            if (item_results.size() > 0)
                item_results[item_results.size()-1].last = 1'b1;
        end
    endtask

    // called and returns at a falling edge
    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] data, input logic [AGE_W-1:0] age,
                             input logic typed, input t_sensor_result want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_byte_index <= idx;
        i_data_byte  <= data;
        i_age        <= age;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        detect_changes(cmd, idx, data, age);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (item_results[k])
                pending_results.push_back(item_results[k]);
        if (cmd == CMD_READ || idx < DUMP_BYTES)
            counted_items++;
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] next_byte(input int idx);
        logic [BYTE_W-1:0] was;
        was = last_scan[idx];
        case ($urandom_range(0, 9))
            0, 1, 2: return was;
            3, 4, 5: return was ^ (8'd1 << $urandom_range(0, 7));
            6:       return was ^ (8'd1 << $urandom_range(0, 7)) ^ (8'd1 << $urandom_range(0, 7));
            7, 8:    return BYTE_W'($urandom);
            default: return ~was;
        endcase
    endfunction

    // receiver side
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sensor_result got;
        t_sensor_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{t_kind'(o_kind), o_module_res, o_pin, o_level, o_any_rising,
                    o_history_count, o_entry_valid, o_last};
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result at cycle %0d: %s", cycle_count, fmt_result(got));
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(got));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int pick;
        int lo;
        int hi;
        int drained;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_SCAN;
        i_byte_index = '0;
        i_data_byte  = '0;
        i_age        = '0;
        foreach (last_scan[k])
            last_scan[k] = '0;
        foreach (rise_log[k])
            rise_log[k] = '0;
        log_head  = 0;
        log_fill  = 0;
        scan_rose = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].command, DIRECTED[i].byte_index, DIRECTED[i].data_byte,
                      DIRECTED[i].age, DIRECTED[i].typed, DIRECTED[i].want);

        // long output hold-off while random items keep coming
        counted_items = 0;
        hold_req = 1'b1;
        while (counted_items < RANDOM_ITEMS) begin
            case ((counted_items / 40) % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 81; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 81; end
                default: begin sender_idle_pct = 14; stall_pct = 14; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                for (int b = 0; b < DUMP_BYTES; b++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(CMD_READ, INDEX_W'($urandom), BYTE_W'($urandom),
                                  AGE_W'($urandom), 1'b0, NO_RESULT);
                    send_item(CMD_SCAN, INDEX_W'(b), next_byte(b), AGE_W'($urandom),
                              1'b0, NO_RESULT);
                end
            end else if (pick < 80) begin
                send_item(CMD_READ, INDEX_W'($urandom), BYTE_W'($urandom),
                          AGE_W'($urandom), 1'b0, NO_RESULT);
            end else if (pick < 90) begin
                lo = $urandom_range(0, DUMP_BYTES - 1);
                send_item(CMD_SCAN, INDEX_W'(lo), next_byte(lo), AGE_W'($urandom),
                          1'b0, NO_RESULT);
            end else if (pick < 95) begin
                lo = $urandom_range(0, DUMP_BYTES - 1);
                hi = $urandom_range(lo, DUMP_BYTES - 1);
                for (int b = lo; b <= hi; b++)
                    send_item(CMD_SCAN, INDEX_W'(b), next_byte(b), AGE_W'($urandom),
                              1'b0, NO_RESULT);
            end else begin
                send_item(CMD_SCAN, INDEX_W'($urandom_range(DUMP_BYTES, 15)),
                          BYTE_W'($urandom), AGE_W'($urandom), 1'b0, NO_RESULT);
            end
        end
        i_valid <= 1'b0;

        drained = 0;
        while (pending_results.size() != 0 && drained < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/fscd_pkg.sv
sv/fscd_bitscan.sv
sv/fscd_history.sv
sv/feedback_sensor_change_detector_core.sv
dv/feedback_sensor_change_detector_core_tb.sv
